>>> hdl/vd7_pkg.sv
// shared types and constants for the 7-bit group varint decoder
// no dependencies; used by the channel interfaces, the core and its checker
`timescale 1ns / 1ps
`default_nettype none

package vd7_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned ACC_W   = 28;
    localparam int unsigned CNT_W   = 3;

    // groups taken before the fifth, top-nibble byte
    localparam logic [CNT_W-1:0] MAX_GROUPS = 3'd4;

    localparam logic [BYTE_W-1:0] CONT_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] SIGN_MASK = 8'h40;
    localparam logic [BYTE_W-1:0] LOW6_MASK = 8'h3F;
    localparam logic [BYTE_W-1:0] LOW7_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] OVF_MASK  = 8'hF0;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_END = 2'd1,
        ST_OVF = 2'd2
    } t_status;

endpackage

`default_nettype wire

>>> hdl/vd7_if.sv
// valid/ready channel interfaces: encoded byte in, decoded integer out
// depends on vd7_pkg for widths and the status type
`timescale 1ns / 1ps
`default_nettype none

interface vd7_in_if;
    logic                          valid;
    logic                          ready;
    logic [vd7_pkg::BYTE_W-1:0]    data_byte;
    logic                          stream_end;
    logic                          signed_mode;

    modport source (output valid, output data_byte, output stream_end,
                    output signed_mode, input ready);
    modport sink   (input valid, input data_byte, input stream_end,
                    input signed_mode, output ready);
endinterface

interface vd7_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [vd7_pkg::VALUE_W-1:0]  value;
    vd7_pkg::t_status                    status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

>>> hdl/varint_7bit_decoder_core.sv
// varint decoder core: input register, group merge logic, result register
// depends on vd7_pkg and the channel interfaces in vd7_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Decodes a little-endian 7-bit group varint into a 32-bit integer, one byte
// per beat. A byte with bit 7 clear ends the integer; a fifth byte supplies bits
// 28..31 and reports overflow if its top nibble is nonzero. With signed_mode set,
// an ending byte among the first four with bit 6 set merges only its low 6 bits
// and the result is inverted. stream_end yields value 0 with status 1 at once.
// Continuation bytes give no result. One byte is accepted every cycle while the
// result side keeps up; a result passes the input register, then the result
// register, and holds there until taken. While a result waits unaccepted, a byte
// in the input register holds, and the input stalls once that register is full.
// Rate is set by the single merge stage that updates the accumulator once per byte.
module varint_7bit_decoder_core (
    input  wire          i_clk,
    input  wire          i_rst_n,
    vd7_in_if.sink       i_in,
    vd7_out_if.source    o_res
);

    logic                           r_s1_valid;
    logic [vd7_pkg::BYTE_W-1:0]     r_s1_byte;
    logic                           r_s1_end;
    logic                           r_s1_sgn;

    logic [vd7_pkg::ACC_W-1:0]      r_acc;
    logic [vd7_pkg::CNT_W-1:0]      r_cnt;
    logic [vd7_pkg::ACC_W-1:0]      n_acc;
    logic [vd7_pkg::CNT_W-1:0]      n_cnt;

    logic                           r_out_valid;
    logic [vd7_pkg::VALUE_W-1:0]    r_out_value;
    vd7_pkg::t_status               r_out_status;
    logic                           n_emit;
    logic [vd7_pkg::VALUE_W-1:0]    n_value;
    vd7_pkg::t_status               n_status;

    logic                           s1_go;
    logic [vd7_pkg::ACC_W-1:0]      grp7;
    logic [vd7_pkg::ACC_W-1:0]      grp6;
    logic [6:0]                     b7;
    logic [6:0]                     b6;

    assign s1_go      = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_s1_valid || s1_go;

    assign o_res.valid  = r_out_valid;
    assign o_res.value  = r_out_value;
    assign o_res.status = r_out_status;

    assign b7 = r_s1_byte[6:0] & vd7_pkg::LOW7_MASK[6:0];
    assign b6 = r_s1_byte[6:0] & vd7_pkg::LOW6_MASK[6:0];

    // place the byte's group at the current group position
    always_comb begin
        case (r_cnt)
            3'd0: begin
                grp7 = {21'd0, b7};
                grp6 = {21'd0, b6};
            end
            3'd1: begin
                grp7 = {14'd0, b7, 7'd0};
                grp6 = {14'd0, b6, 7'd0};
            end
            3'd2: begin
                grp7 = {7'd0, b7, 14'd0};
                grp6 = {7'd0, b6, 14'd0};
            end
            3'd3: begin
                grp7 = {b7, 21'd0};
                grp6 = {b6, 21'd0};
            end
            default: begin
                grp7 = '0;
                grp6 = '0;
            end
        endcase
    end

    always_comb begin
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_emit   = 1'b0;
        n_value  = '0;
        n_status = vd7_pkg::ST_OK;
        if (r_s1_end) begin
            n_emit   = 1'b1;
            n_status = vd7_pkg::ST_END;
        end else if (r_cnt >= vd7_pkg::MAX_GROUPS) begin
            n_emit = 1'b1;
            if ((r_s1_byte & vd7_pkg::OVF_MASK) != '0) begin
                n_status = vd7_pkg::ST_OVF;
            end else begin
                n_value = {r_s1_byte[3:0], r_acc};
            end
        end else if ((r_s1_byte & vd7_pkg::CONT_MASK) == '0) begin
            n_emit = 1'b1;
            if (r_s1_sgn && ((r_s1_byte & vd7_pkg::SIGN_MASK) != '0)) begin
                n_value = ~{4'd0, r_acc | grp6};
            end else begin
                n_value = {4'd0, r_acc | grp7};
            end
        end else begin
            n_acc = r_acc | grp7;
            n_cnt = r_cnt + 3'd1;
        end
        // any result returns the decoder to its idle state
        if (n_emit) begin
            n_acc = '0;
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_byte <= i_in.data_byte;
            r_s1_end  <= i_in.stream_end;
            r_s1_sgn  <= i_in.signed_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else if (s1_go) begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_status <= vd7_pkg::ST_OK;
        end else if (s1_go && n_emit) begin
            r_out_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && n_emit) begin
            r_out_value <= n_value;
        end
    end

endmodule

`default_nettype wire

>>> hdl/vd7_checker.sv
// port-level checker for the varint decoder core, attached by bind
// depends on vd7_pkg and on the core's port names
`timescale 1ns / 1ps
`default_nettype none

module vd7_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire [vd7_pkg::VALUE_W-1:0]   i_out_value,
    input wire [1:0]                    i_out_status
);

    // result register comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status == vd7_pkg::ST_OK ||
                         i_out_status == vd7_pkg::ST_END ||
                         i_out_status == vd7_pkg::ST_OVF))
        else $error("undefined status code");

    // any error beat carries value zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status != vd7_pkg::ST_OK) |-> (i_out_value == '0))
        else $error("error beat with nonzero value");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_value) && $stable(i_out_status)))
        else $error("stalled result beat changed");

endmodule

bind varint_7bit_decoder_core vd7_checker u_vd7_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_value  (o_res.value),
    .i_out_status (o_res.status)
);

`default_nettype wire

>>> dv/varint_7bit_decoder_core_tb.sv
// self-checking bench for varint_7bit_decoder_core: directed and random byte streams
// depends on vd7_pkg, the vd7_in_if / vd7_out_if channels and the core itself
`timescale 1ns / 1ps

module varint_7bit_decoder_core_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 700;
    localparam int IDLE_PCT    = 31;

    typedef struct packed {
        logic [vd7_pkg::BYTE_W-1:0] data_byte;
        logic                       stream_end;
        logic                       signed_mode;
    } t_enc_byte;

    typedef struct {
        logic [vd7_pkg::VALUE_W-1:0] value;
        vd7_pkg::t_status            status;
    } t_decoded;

    logic i_clk = 1'b0;
    logic i_rst_n;

    vd7_in_if  in_ch ();
    vd7_out_if res_ch ();

    varint_7bit_decoder_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    t_enc_byte byte_q[$];
    t_decoded  decoded_q[$];

    // predictor state: groups merged so far and their count
    logic [vd7_pkg::ACC_W-1:0] acc_q = '0;
    logic [vd7_pkg::CNT_W-1:0] grp_q = '0;

    int  beats     = 0;
    int  errors    = 0;
    int  cycles    = 0;
    int  hold_left = 0;
    bit  hold_used = 1'b0;
    wire calm      = (beats >= 300) && (beats < 450);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // returns 1 when the byte closes an integer; r then holds the decoded result
    function automatic bit decode_byte(input logic [vd7_pkg::BYTE_W-1:0] b,
                                       input logic eos, input logic sgn,
                                       output t_decoded r);
        logic [vd7_pkg::VALUE_W-1:0] v;
        int unsigned                 sh;
        r.value  = '0;
        r.status = vd7_pkg::ST_OK;
        if (eos) begin
            r.status = vd7_pkg::ST_END;
        end else if (grp_q >= vd7_pkg::MAX_GROUPS) begin
            // fifth byte: top nibble of the value, no sign rule
            if ((b & vd7_pkg::OVF_MASK) != '0)
                r.status = vd7_pkg::ST_OVF;
            else
                r.value = {b[3:0], acc_q};
        end else begin
            sh = grp_q * 7;
            if ((b & vd7_pkg::CONT_MASK) == '0) begin
                v = {4'h0, acc_q};
                if (sgn && (b & vd7_pkg::SIGN_MASK) != '0)
                    r.value = ~(v | (32'(b & vd7_pkg::LOW6_MASK) << sh));
                else
                    r.value = v | (32'(b & vd7_pkg::LOW7_MASK) << sh);
            end else begin
                v     = 32'(b & vd7_pkg::LOW7_MASK) << sh;
                acc_q = acc_q | v[vd7_pkg::ACC_W-1:0];
                grp_q = grp_q + 1'b1;
                return 1'b0;
            end
        end
        acc_q = '0;
        grp_q = '0;
        return 1'b1;
    endfunction

    task automatic push_byte(input logic [vd7_pkg::BYTE_W-1:0] b, input logic eos,
                             input logic sgn);
        t_enc_byte item;
        item.data_byte   = b;
        item.stream_end  = eos;
        item.signed_mode = sgn;
        byte_q.push_back(item);
    endtask

    // driver: predicts on every accepted beat, then offers the next queued byte
    always @(posedge i_clk) begin
        t_decoded  r;
        t_enc_byte item;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                beats++;
                if (decode_byte(in_ch.data_byte, in_ch.stream_end, in_ch.signed_mode, r))
                    decoded_q.push_back(r);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (byte_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    item = byte_q.pop_front();
                    in_ch.data_byte   <= item.data_byte;
                    in_ch.stream_end  <= item.stream_end;
                    in_ch.signed_mode <= item.signed_mode;
                    in_ch.valid       <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // one long result-side hold-off while bytes keep coming
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (!hold_used && beats >= 500) begin
            hold_left <= 80;
            hold_used <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: compares each result beat with the oldest predicted one
    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result: value %0d status %0d",
                           res_ch.value, res_ch.status);
                    errors++;
                end else begin
                    want = decoded_q.pop_front();
                    if (res_ch.value !== want.value) begin
                        $error("value: expected %0d, got %0d",
                               $signed(want.value), res_ch.value);
                        errors++;
                    end
                    if (res_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, res_ch.status);
                        errors++;
                    end
                end
            end
            res_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("varint_7bit_decoder_core_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int                          len;
        int                          pick;
        logic [vd7_pkg::BYTE_W-1:0]  b;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.data_byte    = '0;
        in_ch.stream_end   = 1'b0;
        in_ch.signed_mode  = 1'b0;
        res_ch.ready       = 1'b0;

        // single-byte values, plain and with the sign rule
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h7F, 1'b0, 1'b0);
        push_byte(8'h7F, 1'b0, 1'b1);
        push_byte(8'h40, 1'b0, 1'b1);
        push_byte(8'h3F, 1'b0, 1'b1);
        // stream end alone (data ignored) and in the middle of an integer
        push_byte(8'hFF, 1'b1, 1'b1);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h00, 1'b1, 1'b0);
        // full five-byte value, all ones
        repeat (4) push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h0F, 1'b0, 1'b1);
        // fifth byte with bit 7 set: overflow
        repeat (5) push_byte(8'h80, 1'b0, 1'b0);
        // sign rule on the fourth byte
        repeat (3) push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h40, 1'b0, 1'b1);

        while (byte_q.size() < RAND_ITEMS + 22) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                // noise: raw bytes with occasional stream ends
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++)
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                              1'($urandom_range(0, 1)));
            end else begin
                pick = $urandom_range(0, 9);
                len  = (pick < 4) ? 1 : (pick < 6) ? 2 : (pick < 7) ? 3 : (pick < 8) ? 4 : 5;
                for (int k = 0; k < len; k++) begin
                    if (k == len - 1 && len == 5)
                        b = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(0, 15));
                    else if (k == len - 1)
                        b = 8'($urandom_range(0, 127));
                    else
                        b = vd7_pkg::CONT_MASK | 8'($urandom_range(0, 127));
                    if ($urandom_range(0, 29) == 0) begin
                        // truncated integer
                        push_byte(b, 1'b1, 1'($urandom_range(0, 1)));
                        break;
                    end
                    push_byte(b, 1'b0, 1'($urandom_range(0, 1)));
                end
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (byte_q.size() == 0 && !in_ch.valid && decoded_q.size() == 0);
        repeat (10) @(posedge i_clk);
        if (errors == 0 && decoded_q.size() == 0)
            $display("varint_7bit_decoder_core_tb: PASS");
        else
            $display("varint_7bit_decoder_core_tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
hdl/vd7_pkg.sv
hdl/vd7_if.sv
hdl/varint_7bit_decoder_core.sv
hdl/vd7_checker.sv
dv/varint_7bit_decoder_core_tb.sv
